[hdl/cle_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cle_pkg;

    localparam int LINE_DEPTH_DEF = 64;

    localparam logic [7:0] KEY_LEFT  = 8'h3C;
    localparam logic [7:0] KEY_RIGHT = 8'h3E;
    localparam logic [7:0] KEY_BACK  = 8'h2D;

    localparam logic ACT_KEY   = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INS,
        OP_DEL,
        OP_SHIFT
    } t_cell_op;

    typedef struct packed {
        t_cell_op    op;
        logic [7:0]  key;
    } t_cell_ctrl;

    typedef enum logic {
        ST_IDLE,
        ST_FLUSH
    } t_state;

endpackage

`default_nettype wire

[hdl/cursor_line_edit_buffer.sv]
`timescale 1ns / 1ps
`default_nettype none

// Keystroke: one transfer per cycle while no line drains, applied in that same cycle; no result.
// End of line: input stalls while the line drains, one character per cycle
// out of slot 0 of the cell row unless the output stalls (an empty line gives
// one transfer); first char passes the FSM state, then the output register.
// Reset (sync, active low) clears cursor, length, drop flag, FSM, output valid.
// Cell contents are not reset; slots beyond the line length are never read.
module cursor_line_edit_buffer
    import cle_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input channel
    input  wire logic       i_in_valid,
    output      logic       o_in_stall,
    input  wire logic       i_action,
    input  wire logic [7:0] i_key_code,
    // output channel
    output      logic       o_out_valid,
    input  wire logic       i_out_stall,
    output      logic [7:0] o_out_char,
    output      logic       o_last,
    output      logic       o_empty_line,
    output      logic       o_overflowed
);

    // cursor and length range over 0..LINE_DEPTH
    localparam int CW = $clog2(LINE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH = CW'(LINE_DEPTH);
    localparam logic [CW-1:0] ONE   = CW'(1);

    // ---------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------
    t_state        r_state, n_state;
    logic [CW-1:0] r_cursor, n_cursor;   // chars left of the cursor
    logic [CW-1:0] r_total, n_total;     // line length
    logic          r_drop, n_drop;       // an insert was dropped this line
    logic [CW-1:0] r_rem, n_rem;         // chars still to drain
    logic          r_empty, n_empty;     // draining line is empty
    logic          r_ovf, n_ovf;         // drop flag latched for the drain

    // output register
    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_out_char, n_out_char;
    logic          r_last, n_last;
    logic          r_empty_line, n_empty_line;
    logic          r_overflowed, n_overflowed;

    logic          in_xfer;
    logic          out_free;
    logic          emit;
    logic          emit_last;

    t_cell_ctrl    cell_ctrl;
    logic [CW-1:0] cell_pos;
    logic [7:0]    w_data [LINE_DEPTH];

    assign in_xfer  = i_in_valid & ~o_in_stall;
    assign out_free = ~r_out_valid | ~i_out_stall;
    assign emit_last = r_empty | (r_rem == ONE);

    // ---------------------------------------------------------------
    // FSM: next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer && i_action == ACT_FLUSH) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (out_free && emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // FSM: outputs
    // ---------------------------------------------------------------
    always_comb begin
        o_in_stall = 1'b1;
        emit       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            ST_FLUSH: begin
                emit = out_free;
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Edit decode: cursor, length and the command to the cell row
    // ---------------------------------------------------------------
    always_comb begin
        n_cursor      = r_cursor;
        n_total       = r_total;
        n_drop        = r_drop;
        n_rem         = r_rem;
        n_empty       = r_empty;
        n_ovf         = r_ovf;
        cell_ctrl.op  = OP_HOLD;
        cell_ctrl.key = i_key_code;
        cell_pos      = r_cursor;

        if (in_xfer) begin
            if (i_action == ACT_FLUSH) begin
                // latch the line for draining and start a fresh one
                n_rem    = r_total;
                n_empty  = (r_total == '0);
                n_ovf    = r_drop;
                n_cursor = '0;
                n_total  = '0;
                n_drop   = 1'b0;
            end else begin
                case (i_key_code)
                    KEY_LEFT: begin
                        if (r_cursor != '0) begin
                            n_cursor = r_cursor - ONE;
                        end
                    end
                    KEY_RIGHT: begin
                        if (r_cursor != r_total) begin
                            n_cursor = r_cursor + ONE;
                        end
                    end
                    KEY_BACK: begin
                        if (r_cursor != '0) begin
                            cell_ctrl.op = OP_DEL;
                            cell_pos     = r_cursor - ONE;
                            n_cursor     = r_cursor - ONE;
                            n_total      = r_total - ONE;
                        end
                    end
                    default: begin
                        if (r_total == DEPTH) begin
                            n_drop = 1'b1;
                        end else begin
                            cell_ctrl.op = OP_INS;
                            n_cursor     = r_cursor + ONE;
                            n_total      = r_total + ONE;
                        end
                    end
                endcase
            end
        end else if (emit && !r_empty) begin
            // drain: slot 0 goes out, the row moves down by one
            cell_ctrl.op = OP_SHIFT;
            n_rem        = r_rem - ONE;
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_comb begin
        n_out_valid  = r_out_valid & i_out_stall;
        n_out_char   = r_out_char;
        n_last       = r_last;
        n_empty_line = r_empty_line;
        n_overflowed = r_overflowed;
        if (emit) begin
            n_out_valid  = 1'b1;
            n_out_char   = r_empty ? 8'h00 : w_data[0];
            n_last       = emit_last;
            n_empty_line = r_empty;
            n_overflowed = r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cursor    <= '0;
            r_total     <= '0;
            r_drop      <= 1'b0;
            r_rem       <= '0;
            r_empty     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cursor    <= n_cursor;
            r_total     <= n_total;
            r_drop      <= n_drop;
            r_rem       <= n_rem;
            r_empty     <= n_empty;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ovf        <= n_ovf;
        r_out_char   <= n_out_char;
        r_last       <= n_last;
        r_empty_line <= n_empty_line;
        r_overflowed <= n_overflowed;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_char   = r_out_char;
    assign o_last       = r_last;
    assign o_empty_line = r_empty_line;
    assign o_overflowed = r_overflowed;

    // ---------------------------------------------------------------
    // Cell row: slot i holds line position i
    // ---------------------------------------------------------------
    for (genvar g = 0; g < LINE_DEPTH; g++) begin : g_cell
        logic [7:0] w_left;
        logic [7:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = 8'h00;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end

        if (g == LINE_DEPTH - 1) begin : g_end
            assign w_right = 8'h00;
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end

        cle_cell #(
            .IDX   (g),
            .POS_W (CW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (cell_ctrl),
            .i_pos        (cell_pos),
            .i_left_data  (w_left),
            .i_right_data (w_right),
            .o_data       (w_data[g])
        );
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_cursor_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= r_total)
        else $error("cursor beyond end of line");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= DEPTH)
        else $error("line length beyond depth");

    a_drain_fresh_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH) |-> (r_total == '0 && r_cursor == '0 && !r_drop))
        else $error("new line not cleared during drain");

    a_last_ends_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && emit_last) |=> (r_state == ST_IDLE && o_out_valid && o_last))
        else $error("drain did not end on last transfer");

endmodule

`default_nettype wire

[hdl/cle_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

// One character slot of the line. Slot IDX holds line position IDX.
module cle_cell
    import cle_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int POS_W = 7
) (
    input  wire logic             i_clk,
    input  wire t_cell_ctrl       i_ctrl,
    input  wire logic [POS_W-1:0] i_pos,
    input  wire logic [7:0]       i_left_data,
    input  wire logic [7:0]       i_right_data,
    output      logic [7:0]       o_data
);

    localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

    logic [7:0] r_data;
    logic [7:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_ctrl.op)
            OP_INS: begin
                // open a gap at the cursor and drop the key into it
                if (MY_IDX > i_pos) begin
                    n_data = i_left_data;
                end else if (MY_IDX == i_pos) begin
                    n_data = i_ctrl.key;
                end
            end
            OP_DEL: begin
                // close up over the removed slot
                if (MY_IDX >= i_pos) begin
                    n_data = i_right_data;
                end
            end
            OP_SHIFT: begin
                n_data = i_right_data;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

[tb/edit_line_checker.sv]
`timescale 1ns / 1ps

// Watches both channels, keeps its own copy of the line and cursor, and
// checks each flushed character against the oldest one still due.
module edit_line_checker
    import cle_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_stall,
    input  wire logic       i_action,
    input  wire logic [7:0] i_key_code,
    input  wire logic       i_out_valid,
    input  wire logic       i_out_stall,
    input  wire logic [7:0] i_out_char,
    input  wire logic       i_last,
    input  wire logic       i_empty_line,
    input  wire logic       i_overflowed,
    output int              o_fail_count,
    output int              o_pending
);

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       empty;
        logic       ovf;
    } t_line_char;

    t_line_char chars_due[$];

    logic [7:0] before_cursor [LINE_DEPTH];
    logic [7:0] after_cursor  [LINE_DEPTH];
    int         n_before;
    int         n_after;
    logic       dropped;
    int         fails = 0;

    task automatic apply_key(input logic [7:0] key);
        if (key == KEY_LEFT) begin
            if (n_before > 0 && n_after < LINE_DEPTH) begin
                n_before = n_before - 1;
                after_cursor[n_after] = before_cursor[n_before];
                n_after = n_after + 1;
            end
        end else if (key == KEY_RIGHT) begin
            if (n_after > 0 && n_before < LINE_DEPTH) begin
                n_after = n_after - 1;
                before_cursor[n_before] = after_cursor[n_after];
                n_before = n_before + 1;
            end
        end else if (key == KEY_BACK) begin
            if (n_before > 0)
                n_before = n_before - 1;
        end else begin
            if (n_before + n_after >= LINE_DEPTH) begin
                dropped = 1'b1;
            end else begin
                before_cursor[n_before] = key;
                n_before = n_before + 1;
            end
        end
    endtask

    // Left stack bottom-up, then right stack top-down; clears the line.
    task automatic emit_line();
        int         total;
        int         k;
        t_line_char c;
        total = n_before + n_after;
        k     = 0;
        c.ovf = dropped;
        if (total == 0) begin
            c.ch    = 8'h00;
            c.last  = 1'b1;
            c.empty = 1'b1;
            chars_due.push_back(c);
        end else begin
            c.empty = 1'b0;
            for (int i = 0; i < n_before; i++) begin
                c.ch   = before_cursor[i];
                c.last = (k + 1 == total);
                chars_due.push_back(c);
                k++;
            end
            for (int i = n_after; i > 0; i--) begin
                c.ch   = after_cursor[i - 1];
                c.last = (k + 1 == total);
                chars_due.push_back(c);
                k++;
            end
        end
        n_before = 0;
        n_after  = 0;
        dropped  = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_line_char want;
        if (!i_rst_n) begin
            chars_due.delete();
            n_before = 0;
            n_after  = 0;
            dropped  = 1'b0;
        end else begin
            // results first: anything leaving now belongs to an earlier line
            if (i_out_valid && !i_out_stall) begin
                if (chars_due.size() == 0) begin
                    $error("unexpected output transfer: out_char %0h last %0b empty_line %0b",
                           i_out_char, i_last, i_empty_line);
                    fails++;
                end else begin
                    want = chars_due.pop_front();
                    if (!want.empty && i_out_char !== want.ch) begin
                        $error("out_char: expected %0h, got %0h", want.ch, i_out_char);
                        fails++;
                    end
                    if (i_last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, i_last);
                        fails++;
                    end
                    if (i_empty_line !== want.empty) begin
                        $error("empty_line: expected %0b, got %0b", want.empty, i_empty_line);
                        fails++;
                    end
                    if (i_overflowed !== want.ovf) begin
                        $error("overflowed: expected %0b, got %0b", want.ovf, i_overflowed);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_action == ACT_FLUSH)
                    emit_line();
                else
                    apply_key(i_key_code);
            end
        end
        o_pending    <= chars_due.size();
        o_fail_count <= fails;
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

// Top of the line-edit buffer bench. Drives keystrokes and end-of-line
// transfers, plays the receiver, and gives the verdict. All prediction and
// comparison lives in edit_line_checker.
module testbench;
    import cle_pkg::*;

    localparam int LINE_DEPTH = LINE_DEPTH_DEF;
    localparam int ITEM_GOAL  = 410;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       i_action   = ACT_KEY;
    logic [7:0] i_key_code = 8'h00;
    logic       i_out_stall = 1'b0;

    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_out_char;
    logic       o_last;
    logic       o_empty_line;
    logic       o_overflowed;

    int         fail_count;
    int         chars_pending;

    int         items_sent = 0;
    bit         burst      = 1'b0;  // no sender gaps while set

    always #4 i_clk = ~i_clk;

    cursor_line_edit_buffer #(
        .LINE_DEPTH (LINE_DEPTH)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_key_code   (i_key_code),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_char   (o_out_char),
        .o_last       (o_last),
        .o_empty_line (o_empty_line),
        .o_overflowed (o_overflowed)
    );

    edit_line_checker #(
        .LINE_DEPTH (LINE_DEPTH)
    ) line_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_key_code   (i_key_code),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_char   (o_out_char),
        .i_last       (o_last),
        .i_empty_line (o_empty_line),
        .i_overflowed (o_overflowed),
        .o_fail_count (fail_count),
        .o_pending    (chars_pending)
    );

    // ---------------------------------------------------------------
    // Sender helpers
    // ---------------------------------------------------------------

    // Optional gap first, then offer the item and hold it until the edge at
    // which the block takes it. Valid is only ever raised here, so it never
    // drops and rises in the same step.
    task automatic send_item(input logic act, input logic [7:0] key);
        int gap;
        int r;
        gap = 0;
        if (!burst) begin
            r = $urandom_range(0, 31);
            if (r == 0)
                gap = $urandom_range(15, 50);   // rare long gap
            else if (r < 10)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_key_code <= key;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    // Plain character: anything that is not an editing key.
    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == KEY_LEFT || b == KEY_RIGHT || b == KEY_BACK);
        return b;
    endfunction

    // Mostly text, with a healthy share of cursor moves and backspaces.
    function automatic logic [7:0] edit_key();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0, 1: return KEY_LEFT;
            2:    return KEY_RIGHT;
            3:    return KEY_BACK;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Sender holds off until the checker has nothing left due. The checker's
    // count is registered, so it drops to zero only in the cycle after the last transfer.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (chars_pending != 0);
    endtask

    // Ordinary line: a few edits, then end of line with a random (ignored) key.
    task automatic type_line(input int edits);
        repeat (edits) send_item(ACT_KEY, edit_key());
        send_item(ACT_FLUSH, 8'($urandom_range(0, 255)));
    endtask

    // Type past capacity with the cursor wandering, so inserts land in the
    // middle of a full line and get dropped.
    task automatic fill_line();
        int inserts;
        int goal;
        inserts = 0;
        goal    = LINE_DEPTH + $urandom_range(1, 6);
        while (inserts < goal) begin
            if ($urandom_range(0, 7) == 0) begin
                send_item(ACT_KEY, KEY_LEFT);
            end else begin
                send_item(ACT_KEY, text_byte());
                inserts++;
            end
        end
        // free one slot and insert again: the drop flag must stick
        send_item(ACT_KEY, KEY_RIGHT);
        send_item(ACT_KEY, KEY_BACK);
        send_item(ACT_KEY, text_byte());
        send_item(ACT_FLUSH, 8'($urandom_range(0, 255)));
    endtask

    // Overflow, then erase every character: empty line that still reports
    // the dropped insert.
    task automatic overflow_then_erase();
        repeat (LINE_DEPTH + 2) send_item(ACT_KEY, text_byte());
        repeat (LINE_DEPTH + 1) send_item(ACT_KEY, KEY_BACK);
        send_item(ACT_FLUSH, 8'h00);
    endtask

    // Unstructured traffic, end-of-line mixed in at random.
    task automatic noise(input int n);
        repeat (n)
            send_item(($urandom_range(0, 5) == 0) ? ACT_FLUSH : ACT_KEY,
                      8'($urandom_range(0, 255)));
    endtask

    // ---------------------------------------------------------------
    // Stimulus and verdict
    // ---------------------------------------------------------------
    initial begin
        int scen;
        int r;
        int guard;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty line, edge-of-line cursor keys, extreme bytes.
        send_item(ACT_FLUSH, 8'h00);       // empty line right after reset
        send_item(ACT_KEY, KEY_LEFT);      // at start: no-op
        send_item(ACT_KEY, KEY_BACK);      // at start: no-op
        send_item(ACT_KEY, KEY_RIGHT);     // at end: no-op
        send_item(ACT_KEY, 8'h00);
        send_item(ACT_KEY, 8'hFF);
        send_item(ACT_KEY, 8'h41);
        send_item(ACT_KEY, KEY_RIGHT);     // at end: no-op
        send_item(ACT_KEY, KEY_LEFT);
        send_item(ACT_KEY, KEY_LEFT);
        send_item(ACT_KEY, 8'h7F);         // insert mid-line
        send_item(ACT_KEY, KEY_BACK);
        send_item(ACT_KEY, KEY_RIGHT);
        send_item(ACT_KEY, KEY_BACK);
        send_item(ACT_KEY, KEY_LEFT);
        send_item(ACT_KEY, KEY_LEFT);
        send_item(ACT_KEY, KEY_LEFT);      // past the start: no-op
        send_item(ACT_KEY, KEY_BACK);      // at start: no-op
        send_item(ACT_FLUSH, 8'hFF);       // key byte ignored on end of line
        wait_drained();

        // Random: mostly well-formed lines, some full-buffer lines, a little
        // noise; periodic full drains so the sender pauses on an idle block.
        scen = 0;
        while (items_sent < ITEM_GOAL) begin
            burst = ($urandom_range(0, 4) == 0);
            r     = $urandom_range(0, 15);
            if (scen == 5)
                overflow_then_erase();
            else if (r == 0)
                fill_line();
            else if (r == 1)
                noise($urandom_range(3, 10));
            else
                type_line($urandom_range(0, 14));
            if (scen % 8 == 7)
                wait_drained();
            scen++;
        end
        burst = 1'b0;

        i_in_valid <= 1'b0;
        guard = 0;
        do begin
            @(posedge i_clk);
            guard++;
        end while (chars_pending != 0 && guard < 100000);
        // let any stray output show up before judging
        repeat (LINE_DEPTH + 8) @(posedge i_clk);
        @(negedge i_clk);

        if (fail_count == 0 && chars_pending == 0) begin
            $display("cursor_line_edit_buffer verification clean");
        end else begin
            $display("cursor_line_edit_buffer verification failed");
        end
        $finish;
    end

    // ---------------------------------------------------------------
    // Receiver: random stall runs, calm stretches, and two long hold-offs
    // while the sender keeps offering, so a draining line backs up into
    // the input stall.
    // ---------------------------------------------------------------
    initial begin
        int stall_left;
        int calm_left;
        int seen;
        int holds_done;
        int r;
        stall_left = 0;
        calm_left  = 0;
        seen       = 0;
        holds_done = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall)
                seen++;
            if (stall_left == 0) begin
                if ((holds_done == 0 && seen >= 30) || (holds_done == 1 && seen >= 200)) begin
                    holds_done++;
                    stall_left = 400;
                end else if (calm_left > 0) begin
                    calm_left--;
                end else begin
                    r = $urandom_range(0, 31);
                    if (r == 0)
                        stall_left = $urandom_range(15, 50);
                    else if (r < 9)
                        stall_left = $urandom_range(1, 3);
                    else if (r == 31)
                        calm_left = $urandom_range(30, 120);
                end
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Hard stop far beyond the slowest legal run.
    initial begin
        #4000000;
        $display("cursor_line_edit_buffer verification failed");
        $finish;
    end

endmodule
